>>> design/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII block
// Digit count, BCD layout and the item handed from converter to emitter.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int unsigned BIN_W         = 32;
    localparam int unsigned DIGITS        = 10;
    localparam int unsigned NIB_W         = 4;
    localparam int unsigned BCD_W         = DIGITS * NIB_W;
    localparam int unsigned CNT_W         = 4;
    localparam int unsigned CHAR_W        = 6;
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned STEPS         = BIN_W / BITS_PER_STEP;
    localparam int unsigned STEP_W        = $clog2(STEPS);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'h39;

    typedef logic [BCD_W-1:0] t_bcd;
    typedef logic [CNT_W-1:0] t_count;

    // one converted number: digits right-aligned, plus its digit count
    typedef struct packed {
        t_bcd   bcd;
        t_count count;
    } t_queue_item;

endpackage

>>> design/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 32-bit unsigned to decimal ASCII characters
// Converter, queue and emitter; one character per transfer, leading zeros
// suppressed, digit count and last flag on every character.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   input    | push / full      | i_value[31:0]
//   result   | empty / pop      | o_digit_char[5:0], o_digit_count[3:0],
//            |                  | o_is_last
//
// The converter takes four bits a cycle and hands each number to the queue,
// taking the next number in that same cycle.
// The emitter sends one character per cycle while the result side keeps
// popping; a number has 1 to 10 characters, and the next one is loaded as the last is sent.
// Reset (synchronous, active low) empties queue and output register.
// A stalled result side fills the queue, then holds full high.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bda_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BIN_W-1:0]  i_value,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic [CNT_W-1:0]  o_digit_count,
    output logic              o_is_last
);

    t_queue_item f_item;
    t_queue_item q_item;
    logic        f_push;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    bda_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_value  (i_value),
        .o_q_push (f_push),
        .i_q_full (q_full),
        .o_q_item (f_item)
    );

    bda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    bda_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_is_last     (o_is_last)
    );

endmodule

>>> design/bda_front.sv
// ----------------------------------------------------------------------------
// bda_front: binary to BCD converter
// Shift-add-3 over four input bits per cycle, then count significant digits.
// ----------------------------------------------------------------------------
module bda_front import bda_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BIN_W-1:0]  i_value,
    output logic              o_q_push,
    input  logic              i_q_full,
    output t_queue_item       o_q_item
);

    logic [BIN_W-1:0]  r_bin, n_bin;
    t_bcd              r_bcd, n_bcd;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              accept;
    t_bcd              step_bcd;
    t_count            digit_cnt;

    assign full     = r_busy | (r_done & i_q_full);
    assign accept   = push & ~full;
    assign o_q_push = r_done & ~i_q_full;

    // four dependent add-3 and shift steps on the BCD word
    always_comb begin
        logic [BIN_W-1:0] bin;
        t_bcd             bcd;
        bin = r_bin;
        bcd = r_bcd;
        for (int j = 0; j < BITS_PER_STEP; j++) begin
            for (int k = 0; k < DIGITS; k++) begin
                if (bcd[k*NIB_W +: NIB_W] >= 4'd5) begin
                    bcd[k*NIB_W +: NIB_W] = bcd[k*NIB_W +: NIB_W] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[BIN_W-1]};
            bin = {bin[BIN_W-2:0], 1'b0};
        end
        n_bin    = bin;
        step_bcd = bcd;
    end

    always_comb begin
        n_bcd = step_bcd;
    end

    // highest nonzero digit sets the count; zero still gives one digit
    always_comb begin
        digit_cnt = t_count'(1);
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[k*NIB_W +: NIB_W] != '0) begin
                digit_cnt = t_count'(k + 1);
            end
        end
    end

    assign o_q_item.bcd   = r_bcd;
    assign o_q_item.count = digit_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (o_q_push) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    a_busy_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("converter busy and done at once");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && i_q_full && !push) |=> (r_done && $stable(r_bcd)))
        else $error("finished number lost while queue full");

endmodule

>>> design/bda_queue.sv
// ----------------------------------------------------------------------------
// bda_queue: small FIFO between converter and digit emitter
// Register storage with a read pointer mux; first word visible at once.
// ----------------------------------------------------------------------------
module bda_queue import bda_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_queue_item i_item,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output t_queue_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_Q = $clog2(DEPTH + 1);

    t_queue_item      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_Q-1:0] r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_fill == CNT_Q'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_Q'(DEPTH))
        else $error("queue fill count out of range");

endmodule

>>> design/bda_back.sv
// ----------------------------------------------------------------------------
// bda_back: digit emitter
// Shifts the significant digits out most significant first into an output
// register, one character per cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module bda_back import bda_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_queue_item       i_q_item,
    output logic              o_q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic [CNT_W-1:0]  o_digit_count,
    output logic              o_is_last
);

    t_bcd              r_sh;
    t_count            r_left;
    t_count            r_cnt;
    logic              r_active;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    t_count            r_count;
    logic              r_last;
    logic              adv;
    logic              emit;
    logic              last_digit;
    logic              load;
    logic [5:0]        shamt;

    assign adv        = ~r_valid | pop;
    assign emit       = r_active & adv;
    assign last_digit = (r_left == t_count'(1));
    assign load       = ~i_q_empty & (~r_active | (emit & last_digit));
    assign o_q_pop    = load;

    // left-align the first significant digit
    assign shamt = {t_count'(DIGITS) - i_q_item.count, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
            end else if (emit && last_digit) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sh   <= i_q_item.bcd << shamt;
            r_left <= i_q_item.count;
            r_cnt  <= i_q_item.count;
        end else if (emit) begin
            r_sh   <= {r_sh[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
            r_left <= r_left - 1'b1;
        end
        if (emit) begin
            r_char  <= ASCII_ZERO + {2'b00, r_sh[BCD_W-1 -: NIB_W]};
            r_count <= r_cnt;
            r_last  <= last_digit;
        end
    end

    assign empty         = ~r_valid;
    assign o_digit_char  = r_char;
    assign o_digit_count = r_count;
    assign o_is_last     = r_last;

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_left != '0 && r_left <= r_cnt))
        else $error("digit counter out of range");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_digit_char >= ASCII_ZERO && o_digit_char <= ASCII_NINE))
        else $error("emitted character is not a decimal digit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_digit_char) && $stable(o_is_last)))
        else $error("waiting character changed before transfer");

endmodule
